>>> rtl/core/tccw_pkg.sv
// shared constants, codes and transaction types of the text console cell writer
package tccw_pkg;

  localparam int COLS    = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLS * ROWS;
  localparam int SHIFT_N = CELLS - COLS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;

  localparam logic [CELL_W-1:0] RESET_BLANK = 16'h0F20;
  localparam logic [7:0]        BLANK_CHAR  = 8'h20;
  localparam logic [7:0]        CH_NEWLINE  = 8'h0A;
  localparam logic [7:0]        CH_RETURN   = 8'h0D;
  localparam logic [7:0]        CH_BACKSPACE = 8'h08;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic       CFG_FG = 1'b0;
  localparam logic       CFG_BG = 1'b1;
  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        end_of_write;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [10:0] hw_cursor;
    logic [15:0] read_data;
    logic        scrolled;
  } out_t;

  // cell write and scroll request from the cursor unit
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
    logic              scroll;
  } put_t;

  // cursor values after the current cycle
  typedef struct packed {
    logic [ADDR_W-1:0] pos;
    logic [ADDR_W-1:0] hw;
  } cur_t;

  // result strobe from the sequencer
  typedef struct packed {
    logic valid;
    logic scrolled;
    logic use_rdata;
  } emit_t;

endpackage

>>> rtl/core/text_console_cell_writer.sv
// top level of the text console cell writer: config registers, cell ram, result register
//
// an 80x25 store of 16-bit text cells (character in the low byte, attribute
// background*16+foreground in the high byte) plus a cursor and a displayed
// cursor. a transaction is accepted on a clock edge with start high and busy
// low; exactly one result follows, shown on out_data for one cycle with
// out_valid high, and the receiver cannot stall it. a put that does not
// scroll and unused requests give their result in the cycle after acceptance
// and leave busy low, so one may be accepted every cycle. a read passes
// through the cell ram's registered read port and then the result register.
// clear writes one cell per cycle through the ram write port, over the whole
// store, before busy drops. a put that scrolls copies the store up one row
// through the ram (one read and one write per cycle) and then blanks the
// bottom row one cell per cycle. after reset busy stays high while the store
// is cleared to blank 0x0F20; config writes are taken at any time and apply
// to later transactions.
module text_console_cell_writer import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // input transactions
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  // results
  output logic       out_valid,
  output out_t       out_data,
  // config writes
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [3:0] cfg_data
);

  logic [3:0]        fg_r, fg_nxt;
  logic [3:0]        bg_r, bg_nxt;
  logic [7:0]        attr;
  logic              out_valid_r;
  out_t              out_data_r;
  put_t              put;
  cur_t              cur;
  emit_t             emit;
  logic              put_fire;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // attribute of new cells
  assign attr = {bg_r, fg_r};

  // config register writes
  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FG:  fg_nxt = cfg_data;
        CFG_BG:  bg_nxt = cfg_data;
        default: fg_nxt = fg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  // cursor tracking and put decode
  tccw_cursor u_cursor (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (put_fire),
    .char_code    (in_data.char_code),
    .end_of_write (in_data.end_of_write),
    .attr         (attr),
    .put          (put),
    .cur          (cur)
  );

  // request sequencing and the long passes over the store
  tccw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .put       (put),
    .attr      (attr),
    .ram_rdata (ram_rdata),
    .busy      (busy),
    .put_fire  (put_fire),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .emit      (emit)
  );

  // cell store
  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register, cursor values are the ones after this cycle's update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data_r.cursor_pos <= POS_W'(cur.pos);
      out_data_r.hw_cursor  <= POS_W'(cur.hw);
      out_data_r.read_data  <= emit.use_rdata ? ram_rdata : '0;
      out_data_r.scrolled   <= emit.scrolled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/tccw_ram.sv
// generic simple dual-port ram with registered read
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tccw_cursor.sv
// cursor unit: row, column and linear cursor, displayed cursor, put decode
module tccw_cursor import tccw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] char_code,
  input  logic       end_of_write,
  input  logic [7:0] attr,
  output put_t       put,
  output cur_t       cur
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] hw_r, hw_nxt;
  logic              last_col, last_row;

  assign last_col = (col_r == COL_W'(COLS - 1));
  assign last_row = (row_r == ROW_W'(ROWS - 1));

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    hw_nxt     = hw_r;
    put.we     = 1'b0;
    put.addr   = pos_r;
    put.data   = {attr, char_code};
    put.scroll = 1'b0;
    if (fire) begin
      unique case (char_code)
        CH_NEWLINE: begin
          col_nxt = '0;
          if (last_row) begin
            put.scroll = 1'b1;
            pos_nxt    = ADDR_W'(SHIFT_N);
          end else begin
            row_nxt = row_r + 1'b1;
            pos_nxt = pos_r + ADDR_W'(COLS) - ADDR_W'(col_r);
          end
        end
        CH_RETURN: begin
          col_nxt = '0;
          pos_nxt = pos_r - ADDR_W'(col_r);
        end
        CH_BACKSPACE: begin
          // ignored at cell zero
          if (pos_r != '0) begin
            pos_nxt  = pos_r - 1'b1;
            put.we   = 1'b1;
            put.addr = pos_r - 1'b1;
            put.data = {attr, BLANK_CHAR};
            if (col_r == '0) begin
              col_nxt = COL_W'(COLS - 1);
              row_nxt = row_r - 1'b1;
            end else begin
              col_nxt = col_r - 1'b1;
            end
          end
        end
        default: begin
          put.we = 1'b1;
          if (last_col) begin
            col_nxt = '0;
            if (last_row) begin
              put.scroll = 1'b1;
              pos_nxt    = ADDR_W'(SHIFT_N);
            end else begin
              row_nxt = row_r + 1'b1;
              pos_nxt = pos_r + 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
            pos_nxt = pos_r + 1'b1;
          end
        end
      endcase
      if (end_of_write) begin
        hw_nxt = pos_nxt;
      end
    end
  end

  assign cur.pos = pos_nxt;
  assign cur.hw  = hw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      pos_r <= '0;
      hw_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      pos_r <= pos_nxt;
      hw_r  <= hw_nxt;
    end
  end

endmodule

>>> rtl/core/tccw_seq.sv
// sequencer: request decode, fill, scroll and read passes over the cell ram
module tccw_seq import tccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_t               in_data,
  input  put_t              put,
  input  logic [7:0]        attr,
  input  logic [CELL_W-1:0] ram_rdata,
  output logic              busy,
  output logic              put_fire,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  output emit_t             emit
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FILL  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_BLANK = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic              clr_pend_r, clr_pend_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              accept;
  logic              idx_ok;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign put_fire = accept && (in_data.req_type == REQ_PUT);
  assign idx_ok   = ({21'b0, in_data.cell_index} < 32'(CELLS));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    clr_pend_nxt = clr_pend_r;
    rd_ok_nxt    = rd_ok_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r;
    ram_wdata    = fill_r;
    ram_re       = 1'b0;
    ram_raddr    = ADDR_W'(in_data.cell_index);
    emit         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            REQ_PUT: begin
              ram_we    = put.we;
              ram_waddr = put.addr;
              ram_wdata = put.data;
              fill_nxt  = {attr, BLANK_CHAR};
              if (put.scroll) begin
                state_nxt = ST_SHIFT;
                cnt_nxt   = '0;
              end else begin
                emit.valid = 1'b1;
              end
            end
            REQ_CLEAR: begin
              fill_nxt     = {attr, BLANK_CHAR};
              clr_pend_nxt = 1'b1;
              cnt_nxt      = '0;
              state_nxt    = ST_FILL;
            end
            REQ_READ: begin
              ram_re    = idx_ok;
              rd_ok_nxt = idx_ok;
              state_nxt = ST_READ;
            end
            default: begin
              emit.valid = 1'b1;
            end
          endcase
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          emit.valid   = clr_pend_r;
          clr_pend_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_READ: begin
        emit.valid     = 1'b1;
        emit.use_rdata = rd_ok_r;
        state_nxt      = ST_IDLE;
      end
      ST_SHIFT: begin
        // read one row ahead, and write the word returned by the registered read port one row up
        ram_re    = (cnt_r != ADDR_W'(SHIFT_N));
        ram_raddr = cnt_r + ADDR_W'(COLS);
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - 1'b1;
        ram_wdata = ram_rdata;
        if (cnt_r == ADDR_W'(SHIFT_N)) begin
          state_nxt = ST_BLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          emit.valid    = 1'b1;
          emit.scrolled = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      cnt_r      <= '0;
      fill_r     <= RESET_BLANK;
      clr_pend_r <= 1'b0;
      rd_ok_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      fill_r     <= fill_nxt;
      clr_pend_r <= clr_pend_nxt;
      rd_ok_r    <= rd_ok_nxt;
    end
  end

endmodule
